// ===== hw/rtl/ipc_pkg.sv =====
package ipc_pkg;

  // Default parameter values.
  localparam int ANGLE_BITS_DEF     = 16;
  localparam int SINE_FRAC_BITS_DEF = 15;

  // Fixed-point constants.
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [17:0] SQRT3_Q16   = 18'd113512;

  // Horner steps of the quarter-wave sine series, with the divisor of each step
  // and floor(2^32 / divisor) for the reciprocal multiply.
  localparam int SERIES_STEPS = 6;
  localparam logic [7:0] SERIES_DIV [SERIES_STEPS] =
    '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] SERIES_RECIP [SERIES_STEPS] =
    '{30'd27531841, 30'd39045157, 30'd59652323,
      30'd102261126, 30'd214748364, 30'd715827882};

  // Sine unit latency: angle fold, square, three stages per step, product, round.
  localparam int SIN_LAT = 2 + 3 * SERIES_STEPS + 2;

  // Compare divider: 32-bit dividend, 16-bit quotient, one bit per stage.
  localparam int NUM_W = 32;
  localparam int QUO_W = 16;

  // Register map.
  typedef enum logic [1:0] {
    REG_SUPPLY = 2'd0,
    REG_PERIOD = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_t;

  localparam logic [15:0] SUPPLY_RST = 16'd3072;
  localparam logic [15:0] PERIOD_RST = 16'd1000;
  localparam logic [15:0] OFFSET_RST = 16'd0;

endpackage

// ===== hw/rtl/ipc_sine.sv =====
module ipc_sine #(
  parameter int ANGLE_BITS     = ipc_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = ipc_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ANGLE_BITS-1:0]            theta,
  output logic signed [SINE_FRAC_BITS+1:0] sine
);
  import ipc_pkg::*;

  localparam int QB = ANGLE_BITS - 2;
  localparam int SH = 30 - SINE_FRAC_BITS;
  localparam int NEG_LAT = SIN_LAT - 1;
  localparam logic [QB:0] P_FULL = (QB + 1)'(1) << QB;
  localparam logic [31:0] RND_HALF = 32'(1) << (SH - 1);

  logic [1:0]    quad;
  logic [QB:0]   p;
  logic [QB+31:0] xprod;
  logic [30:0]   x1_r;
  logic [61:0]   xx;
  logic [30:0]   x_s  [0:SERIES_STEPS];
  logic [31:0]   x2_s [0:SERIES_STEPS-1];
  logic [30:0]   t_s  [0:SERIES_STEPS];
  logic [30:0]   xf_r;
  logic [31:0]   x2f_r;
  logic          neg_r [1:NEG_LAT];
  logic [61:0]   fprod;
  logic [30:0]   s_r;
  logic [31:0]   rnd;
  logic [SINE_FRAC_BITS+1:0] mag;
  logic signed [SINE_FRAC_BITS+1:0] sine_nxt;
  logic signed [SINE_FRAC_BITS+1:0] sine_r;

  // Fold the angle into the first quadrant.
  assign quad  = theta[ANGLE_BITS-1 -: 2];
  assign p     = quad[0] ? (P_FULL - {1'b0, theta[QB-1:0]}) : {1'b0, theta[QB-1:0]};
  assign xprod = p * HALF_PI_Q30;
  assign xx    = x1_r * x1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r     <= xprod[QB+30:QB];
      xf_r     <= x1_r;
      x2f_r    <= xx[61:30];
      neg_r[1] <= quad[1];
      for (int k = 2; k <= NEG_LAT; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign x_s[0]  = xf_r;
  assign x2_s[0] = x2f_r;
  assign t_s[0]  = Q30_ONE;

  for (genvar i = 0; i < SERIES_STEPS; i++) begin : g_step
    logic [62:0] pr_nxt;
    logic [62:0] pr_r;
    logic [31:0] m_nxt;
    logic [61:0] mr_nxt;
    logic [31:0] m_r;
    logic [61:0] mr_r;
    logic [29:0] q0;
    logic [37:0] qc;
    logic [32:0] rem;
    logic        ge;
    logic [30:0] t_nxt;
    logic [30:0] t_r;
    logic [30:0] xa_r;
    logic [30:0] xb_r;
    logic [30:0] xc_r;

    assign pr_nxt = x2_s[i] * t_s[i];
    assign m_nxt  = pr_r[61:30];
    assign mr_nxt = m_nxt * SERIES_RECIP[i];
    // The reciprocal estimate is low by at most one; one compare fixes it.
    assign q0     = mr_r[61:32];
    assign qc     = q0 * SERIES_DIV[i];
    assign rem    = {1'b0, m_r} - qc[32:0];
    assign ge     = rem >= {25'd0, SERIES_DIV[i]};
    assign t_nxt  = Q30_ONE - ({1'b0, q0} + {30'd0, ge});

    always_ff @(posedge clk) begin
      if (en) begin
        pr_r <= pr_nxt;
        xa_r <= x_s[i];
        m_r  <= m_nxt;
        mr_r <= mr_nxt;
        xb_r <= xa_r;
        t_r  <= t_nxt;
        xc_r <= xb_r;
      end
    end

    assign t_s[i+1] = t_r;
    assign x_s[i+1] = xc_r;

    if (i < SERIES_STEPS - 1) begin : g_x2
      logic [31:0] x2a_r;
      logic [31:0] x2b_r;
      logic [31:0] x2c_r;
      always_ff @(posedge clk) begin
        if (en) begin
          x2a_r <= x2_s[i];
          x2b_r <= x2a_r;
          x2c_r <= x2b_r;
        end
      end
      assign x2_s[i+1] = x2c_r;
    end
  end

  assign fprod    = x_s[SERIES_STEPS] * t_s[SERIES_STEPS];
  assign rnd      = {1'b0, s_r} + RND_HALF;
  assign mag      = rnd[31:SH];
  assign sine_nxt = neg_r[NEG_LAT] ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= fprod[60:30];
      sine_r <= sine_nxt;
    end
  end

  assign sine = sine_r;

endmodule

// ===== hw/rtl/ipc_div.sv =====
module ipc_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ipc_pkg::NUM_W-1:0]  num,
  input  logic [ipc_pkg::QUO_W-1:0]  den,
  output logic [ipc_pkg::QUO_W-1:0]  quo
);
  import ipc_pkg::*;

  // The quotient is known to fit in QUO_W bits, so the upper half of the
  // dividend is already below the divisor.
  logic [QUO_W-1:0] rem_s [0:QUO_W-1];
  logic [QUO_W-1:0] sh_s  [0:QUO_W];

  assign rem_s[0] = num[NUM_W-1:QUO_W];
  assign sh_s[0]  = num[QUO_W-1:0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_bit
    logic [QUO_W:0]   trial;
    logic [QUO_W:0]   diff;
    logic             ge;
    logic [QUO_W-1:0] sh_r;

    assign trial = {rem_s[k], sh_s[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, den};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        sh_r <= {sh_s[k][QUO_W-2:0], ge};
      end
    end
    assign sh_s[k+1] = sh_r;

    if (k < QUO_W - 1) begin : g_rem
      logic [QUO_W-1:0] rem_r;
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r <= ge ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
        end
      end
      assign rem_s[k+1] = rem_r;
    end
  end

  assign quo = sh_s[QUO_W];

endmodule

// ===== hw/rtl/inverse_park_clarke_pwm_duty.sv =====
// Sinusoidal PWM duty generator. Each input item carries a signed Q8.8
// quadrature voltage and a 16-bit electrical angle (65536 counts per turn).
// The voltage is limited to plus or minus half the supply (flagged in
// voltage_clamped), the angle offset is added with wrap-around, and inverse
// Park and inverse Clarke transforms with zero direct-axis voltage give three
// phase voltages centered on half the supply. Each phase is scaled to a
// compare value in 0..pwm_period. The block is a fully pipelined datapath:
// it takes one item every clock cycle unless the output stalls, with a
// depth set mostly by the six-step sine series unit (22 stages) and the
// one-bit-per-stage compare divider (16 stages). Backpressure on the output
// stalls the whole pipeline, so in_tready follows out_tready whenever a
// result is waiting. The user must write registers through the APB-style
// port only while no item is in flight; the block does not enforce this:
// supply_voltage at 0x0, pwm_period at 0x4 and angle_offset at 0x8. A zero
// supply forces all compare values to zero.
module inverse_park_clarke_pwm_duty #(
  parameter int ANGLE_BITS     = ipc_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = ipc_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // quad_voltage[15:0], elec_angle[31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,    // compare_a[15:0], compare_b[31:16],
                                    // compare_c[47:32], voltage_clamped[48]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ipc_pkg::*;

  // Stage numbering: 1 is the entry register, the sine unit output lands in
  // ST_SIN, then five arithmetic stages, then the divider.
  localparam int ST_SIN = 1 + SIN_LAT;
  localparam int LAT    = ST_SIN + 5 + QUO_W;
  localparam int SW     = SINE_FRAC_BITS + 2;
  localparam int PW     = 18 + SW;
  localparam int RS     = SINE_FRAC_BITS - 7;
  localparam logic [PW-1:0] RS_HALF = PW'(1) << (RS - 1);
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  // Configuration registers.
  logic [15:0] supply_r;
  logic [15:0] period_r;
  logic [15:0] offset_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RST;
      period_r <= PERIOD_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SUPPLY: supply_r <= cfg_pwdata[15:0];
        REG_PERIOD: period_r <= cfg_pwdata[15:0];
        REG_OFFSET: offset_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SUPPLY: cfg_prdata = {16'd0, supply_r};
      REG_PERIOD: cfg_prdata = {16'd0, period_r};
      REG_OFFSET: cfg_prdata = {16'd0, offset_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // The whole pipeline advances together unless the output holds a result
  // that the sink has not taken.
  logic adv;
  logic vld_r [1:LAT];

  assign adv       = !vld_r[LAT] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[1] <= in_tvalid;
      for (int k = 2; k <= LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Entry: voltage limit and angle offset. The voltage is doubled so that
  // half the supply equals supply_voltage in the same units.
  logic signed [15:0] q_in;
  logic signed [17:0] v_dbl;
  logic signed [17:0] lim;
  logic signed [17:0] v_nxt;
  logic               clamp_nxt;
  logic [15:0]        a16;
  logic [ANGLE_BITS-1:0] theta_nxt;

  assign q_in  = $signed(in_tdata[15:0]);
  assign v_dbl = 18'(q_in) <<< 1;
  assign lim   = $signed({2'b00, supply_r});
  assign a16   = in_tdata[31:16] + offset_r;

  always_comb begin
    v_nxt     = v_dbl;
    clamp_nxt = 1'b0;
    if (v_dbl > lim) begin
      v_nxt     = lim;
      clamp_nxt = 1'b1;
    end else if (v_dbl < -lim) begin
      v_nxt     = -lim;
      clamp_nxt = 1'b1;
    end
  end

  if (ANGLE_BITS >= 16) begin : g_ang_wide
    assign theta_nxt = ANGLE_BITS'(a16) << (ANGLE_BITS - 16);
  end else begin : g_ang_narrow
    assign theta_nxt = a16[15 -: ANGLE_BITS];
  end

  logic [ANGLE_BITS-1:0] theta_r;
  logic [ANGLE_BITS-1:0] theta_cos;
  logic signed [17:0]    v_r     [1:ST_SIN];
  logic                  clamp_r [1:LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      theta_r    <= theta_nxt;
      v_r[1]     <= v_nxt;
      clamp_r[1] <= clamp_nxt;
      for (int k = 2; k <= ST_SIN; k++) begin
        v_r[k] <= v_r[k-1];
      end
      for (int k = 2; k <= LAT; k++) begin
        clamp_r[k] <= clamp_r[k-1];
      end
    end
  end

  // Cosine is the sine a quarter turn ahead.
  assign theta_cos = theta_r + QUARTER;

  logic signed [SW-1:0] sn;
  logic signed [SW-1:0] cs;

  ipc_sine #(
    .ANGLE_BITS    (ANGLE_BITS),
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_sin (
    .clk  (clk),
    .en   (adv),
    .theta(theta_r),
    .sine (sn)
  );

  ipc_sine #(
    .ANGLE_BITS    (ANGLE_BITS),
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_cos (
    .clk  (clk),
    .en   (adv),
    .theta(theta_cos),
    .sine (cs)
  );

  // Inverse Park with zero direct-axis voltage, then rounding of both
  // products half away from zero.
  logic signed [PW-1:0] pa_r;
  logic signed [PW-1:0] pb_r;
  logic [PW-1:0]        ma;
  logic [PW-1:0]        mb;
  logic [PW-1:0]        ra;
  logic [PW-1:0]        rb;
  logic signed [24:0]   alpha_nxt;
  logic signed [24:0]   beta_nxt;
  logic signed [24:0]   alpha_r;
  logic signed [24:0]   beta_r;

  assign ma        = pa_r[PW-1] ? PW'(-pa_r) : PW'(pa_r);
  assign mb        = pb_r[PW-1] ? PW'(-pb_r) : PW'(pb_r);
  assign ra        = (ma + RS_HALF) >> RS;
  assign rb        = (mb + RS_HALF) >> RS;
  assign alpha_nxt = pa_r[PW-1] ? -$signed(ra[24:0]) : $signed(ra[24:0]);
  assign beta_nxt  = pb_r[PW-1] ? -$signed(rb[24:0]) : $signed(rb[24:0]);

  // Inverse Clarke: beta times sqrt(3), then the doubled phase voltages
  // limited to the 0..2*supply range.
  logic signed [24:0] alpha3_r;
  logic signed [43:0] s3p_r;
  logic [43:0]        s3m;
  logic [43:0]        s3r;
  logic signed [27:0] s3b;
  logic signed [29:0] h_ext;
  logic signed [29:0] d_ext;
  logic signed [29:0] ph2 [3];
  logic [24:0]        xph_nxt [3];
  logic [24:0]        xph_r [3];
  logic [31:0]        n_r [3];
  logic [40:0]        nprod [3];

  assign s3m   = s3p_r[43] ? 44'(-s3p_r) : 44'(s3p_r);
  assign s3r   = (s3m + 44'h8000) >> 16;
  assign s3b   = s3p_r[43] ? -$signed(s3r[27:0]) : $signed(s3r[27:0]);
  assign h_ext = $signed({6'd0, supply_r, 8'd0});
  assign d_ext = $signed({5'd0, supply_r, 9'd0});

  assign ph2[0] = (30'(alpha3_r) <<< 1) + h_ext;
  assign ph2[1] = 30'(s3b) - 30'(alpha3_r) + h_ext;
  assign ph2[2] = -30'(alpha3_r) - 30'(s3b) + h_ext;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (ph2[j] <= 0) begin
        xph_nxt[j] = 25'd0;
      end else if (ph2[j] > d_ext) begin
        xph_nxt[j] = d_ext[24:0];
      end else begin
        xph_nxt[j] = ph2[j][24:0];
      end
      nprod[j] = xph_r[j] * period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r     <= -(v_r[ST_SIN] * sn);
      pb_r     <= v_r[ST_SIN] * cs;
      alpha_r  <= alpha_nxt;
      beta_r   <= beta_nxt;
      alpha3_r <= alpha_r;
      s3p_r    <= beta_r * $signed({1'b0, SQRT3_Q16});
      for (int j = 0; j < 3; j++) begin
        xph_r[j] <= xph_nxt[j];
        // Dividing by supply*512 equals dropping nine bits, then dividing.
        n_r[j]   <= nprod[j][40:9];
      end
    end
  end

  logic [QUO_W-1:0] quo [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    ipc_div u_div (
      .clk(clk),
      .en (adv),
      .num(n_r[j]),
      .den(supply_r),
      .quo(quo[j])
    );
  end

  logic zero_sup;
  assign zero_sup = supply_r == 16'd0;

  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = {7'd0, clamp_r[LAT],
                       zero_sup ? 16'd0 : quo[2],
                       zero_sup ? 16'd0 : quo[1],
                       zero_sup ? 16'd0 : quo[0]};

  // A compare value never exceeds the period.
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:0] <= period_r) && (out_tdata[31:16] <= period_r) &&
                   (out_tdata[47:32] <= period_r))
    else $error("compare value above pwm period");

  // An accepted item enters the first stage.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted item lost at entry");

  // A stalled pipeline keeps its occupancy.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> vld_r[LAT] && vld_r[ST_SIN] == $past(vld_r[ST_SIN]))
    else $error("pipeline moved during a stall");

endmodule
